/* hw/rtl/rc4_variant_table_stream_decrypt_macros.svh */
// Assertion macros used by the checker file of the RC4-variant decryptor.
// No dependencies.
`ifndef RC4_VARIANT_TABLE_STREAM_DECRYPT_MACROS_SVH
`define RC4_VARIANT_TABLE_STREAM_DECRYPT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RC4V_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Concurrent assertion that is also checked during reset.
`define RC4V_ASSERT_ANY(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rc4v_pkg.sv */
// Shared constants and types of the RC4-variant table decryptor.
// No dependencies; the front end, queue, back end and top level import it.
package rc4v_pkg;

	localparam int MAX_KEY_BYTES = 256;
	localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);

	// The command queue depth must be a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BYTE_MAX = 8'd255;

	typedef enum logic {
		CMD_KEY  = 1'b0,
		CMD_DATA = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] value;
		logic       last;
	} cmd_t;

endpackage

/* hw/rtl/rc4v_if.sv */
// Valid/ready channel interfaces for the request and result streams.
// No dependencies.
interface rc4v_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] value;
	logic       last_key;

	modport source (output valid, operation, value, last_key, input ready);
	modport sink (input valid, operation, value, last_key, output ready);
endinterface

interface rc4v_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;

	modport source (output valid, plain_byte, input ready);
	modport sink (input valid, plain_byte, output ready);
endinterface

/* hw/rtl/rc4v_front.sv */
// Front end: accepts requests and classifies them into key or data commands.
// Depends on rc4v_pkg and rc4v_in_if.
module rc4v_front (
	input  logic            clk,
	input  logic            arst_n,
	rc4v_in_if.sink         item,
	output logic            push_valid,
	output rc4v_pkg::cmd_t  push_cmd,
	input  logic            push_ready
);
	import rc4v_pkg::*;

	logic cmd_valid_q;
	cmd_t cmd_q;

	assign item.ready = !cmd_valid_q || push_ready;
	assign push_valid = cmd_valid_q;
	assign push_cmd   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else if (item.valid && item.ready) begin
			cmd_valid_q <= 1'b1;
			cmd_q.kind  <= item.operation ? CMD_DATA : CMD_KEY;
			cmd_q.value <= item.value;
			// A last mark only means something on a key byte.
			cmd_q.last  <= item.last_key && !item.operation;
		end else if (push_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/rc4v_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on rc4v_pkg.
module rc4v_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  rc4v_pkg::cmd_t  push_cmd,
	output logic            push_ready,
	output logic            head_valid,
	output rc4v_pkg::cmd_t  head_cmd,
	input  logic            pop
);
	import rc4v_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/rc4v_back.sv */
// Back end: key store, key schedule and table build sequencer, and the
// data path that XORs data bytes with the keystream table.
// Depends on rc4v_pkg and rc4v_out_if.
module rc4v_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  rc4v_pkg::cmd_t  head_cmd,
	output logic            pop,
	rc4v_out_if.source      result
);
	import rc4v_pkg::*;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_INIT,
		ST_KSA_RD,
		ST_KSA_J,
		ST_KSA_WI,
		ST_KSA_WJ,
		ST_FILL_A,
		ST_FILL_B,
		ST_FILL_C,
		ST_FILL_W
	} state_t;

	logic [7:0] key_mem  [MAX_KEY_BYTES];
	logic [7:0] perm_mem [256];
	logic [7:0] tbl_mem  [256];

	state_t               state_q;
	logic [7:0]           i_q;
	logic [7:0]           j_q;
	logic [7:0]           si_q;
	logic [KEY_IDX_W-1:0] k_q;
	logic [KEY_CNT_W-1:0] key_cnt_q;
	logic [KEY_CNT_W-1:0] klen_q;
	logic [7:0]           pos_q;
	logic                 loaded_q;
	logic [7:0]           perm_rd_q;
	logic [7:0]           key_rd_q;
	logic [7:0]           tbl_rd_q;
	logic                 valid_s1;
	logic [7:0]           value_s1;
	logic                 loaded_s1;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;

	logic                 stall;
	logic                 advance;
	logic                 take_key;
	logic                 take_data;
	logic                 cnt_room;
	logic [KEY_CNT_W-1:0] cnt_next;
	logic                 start_build;
	logic                 k_wrap;
	logic [7:0]           j_sum;
	logic [7:0]           perm_raddr;
	logic                 perm_we;
	logic [7:0]           perm_waddr;
	logic [7:0]           perm_wdata;

	assign stall       = valid_s1 && out_valid_q && !result.ready;
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign pop         = (state_q == ST_RUN) && head_valid && !stall;
	assign take_key    = pop && (head_cmd.kind == CMD_KEY);
	assign take_data   = pop && (head_cmd.kind == CMD_DATA);
	assign cnt_room    = key_cnt_q < KEY_CNT_W'(MAX_KEY_BYTES);
	assign cnt_next    = cnt_room ? key_cnt_q + KEY_CNT_W'(1) : key_cnt_q;
	assign start_build = take_key && head_cmd.last && (cnt_next != '0);
	assign k_wrap      = (KEY_CNT_W'(k_q) + KEY_CNT_W'(1)) == klen_q;
	assign j_sum       = j_q + perm_rd_q + key_rd_q;

	assign result.valid      = out_valid_q;
	assign result.plain_byte = out_byte_q;

	always_comb begin
		case (state_q)
			ST_KSA_RD: perm_raddr = i_q;
			ST_KSA_J:  perm_raddr = j_sum;
			ST_FILL_A: perm_raddr = i_q + 8'd1;
			ST_FILL_B: perm_raddr = i_q + 8'd1 + perm_rd_q;
			ST_FILL_C: perm_raddr = si_q + perm_rd_q;
			default:   perm_raddr = i_q;
		endcase
	end

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = i_q;
		perm_wdata = i_q;
		case (state_q)
			ST_INIT: begin
				perm_we = 1'b1;
			end
			ST_KSA_WI: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rd_q;
			end
			ST_KSA_WJ: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			default: begin
				perm_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		perm_rd_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (take_key && cnt_room) begin
			key_mem[key_cnt_q[KEY_IDX_W-1:0]] <= head_cmd.value;
		end
		key_rd_q <= key_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL_W) begin
			tbl_mem[i_q] <= perm_rd_q;
		end
		if (take_data) begin
			tbl_rd_q <= tbl_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			i_q         <= '0;
			j_q         <= '0;
			si_q        <= '0;
			k_q         <= '0;
			key_cnt_q   <= '0;
			klen_q      <= '0;
			pos_q       <= '0;
			loaded_q    <= 1'b0;
			valid_s1    <= 1'b0;
			value_s1    <= '0;
			loaded_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (start_build) begin
						klen_q    <= cnt_next;
						key_cnt_q <= '0;
						i_q       <= '0;
						state_q   <= ST_INIT;
					end else if (take_key) begin
						key_cnt_q <= cnt_next;
					end
				end
				ST_INIT: begin
					i_q <= i_q + 8'd1;
					if (i_q == BYTE_MAX) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_KSA_RD;
					end
				end
				ST_KSA_RD: begin
					state_q <= ST_KSA_J;
				end
				ST_KSA_J: begin
					j_q     <= j_sum;
					si_q    <= perm_rd_q;
					state_q <= ST_KSA_WI;
				end
				ST_KSA_WI: begin
					state_q <= ST_KSA_WJ;
				end
				ST_KSA_WJ: begin
					k_q     <= k_wrap ? '0 : k_q + KEY_IDX_W'(1);
					i_q     <= i_q + 8'd1;
					state_q <= (i_q == BYTE_MAX) ? ST_FILL_A : ST_KSA_RD;
				end
				ST_FILL_A: begin
					state_q <= ST_FILL_B;
				end
				ST_FILL_B: begin
					si_q    <= perm_rd_q;
					state_q <= ST_FILL_C;
				end
				ST_FILL_C: begin
					state_q <= ST_FILL_W;
				end
				ST_FILL_W: begin
					i_q <= i_q + 8'd1;
					if (i_q == BYTE_MAX) begin
						loaded_q <= 1'b1;
						pos_q    <= '0;
						state_q  <= ST_RUN;
					end else begin
						state_q <= ST_FILL_A;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (take_data) begin
				pos_q     <= pos_q + 8'd1;
				value_s1  <= head_cmd.value;
				loaded_s1 <= loaded_q;
			end
			if (take_data) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			// Before the first key the table reads as all zero.
			if (advance) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= value_s1 ^ (loaded_s1 ? tbl_rd_q : 8'd0);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/rc4_variant_table_stream_decrypt.sv */
// Top level of the RC4-variant keystream table decryptor.
// Depends on rc4v_pkg, rc4v_if, rc4v_front, rc4v_cmd_queue and rc4v_back.
//
//  Channel  Direction  Payload                      Request
//  item     in         operation, value, last_key   key byte or data byte
//  result   out        plain_byte                   one per data byte
//
// Key and data bytes are taken at one per cycle while the queue has room;
// the back end stops popping during a build or while its result stalls.
// A key byte marked last starts a table build in the back end: it seeds the
// permutation, runs the key schedule over every entry and then fills the
// table, through the single read port of the permutation memory.
// During a build the command queue fills and item.ready then drops.
// Reset clears the key count, the stream position and the table-loaded flag.
module rc4_variant_table_stream_decrypt (
	input  logic       clk,
	input  logic       arst_n,
	rc4v_in_if.sink    item,
	rc4v_out_if.source result
);
	import rc4v_pkg::*;

	logic push_valid;
	cmd_t push_cmd;
	logic push_ready;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	rc4v_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	rc4v_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	rc4v_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* hw/rtl/rc4v_checker.sv */
// Port-level checker for the RC4-variant decryptor and its bind statement.
// Depends on rc4_variant_table_stream_decrypt_macros.svh.
`include "rc4_variant_table_stream_decrypt_macros.svh"

module rc4v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] plain_byte
);

	`RC4V_ASSERT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result valid dropped while stalled")
	`RC4V_ASSERT(a_out_data_hold, clk, arst_n, out_valid && !out_ready |=> $stable(plain_byte), "result payload changed while stalled")
	`RC4V_ASSERT_ANY(a_reset_quiet, clk, !arst_n |-> !out_valid, "result valid during reset")
	`RC4V_ASSERT_ANY(a_min_latency, clk, $rose(arst_n) |-> ##2 !out_valid, "result too soon after reset")

endmodule

bind rc4_variant_table_stream_decrypt rc4v_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.plain_byte (result.plain_byte)
);
